// File: design/fpavt_pkg.sv
// Shared types and constants for the fixed-point affine vertex transform.
// Used by every module in this folder; has no dependencies of its own.
package fpavt_pkg;

    localparam int WORD_W    = 32;
    localparam int ACC_W     = 64;
    localparam int FRAC_BITS = 12;
    localparam int REG_W     = 64;
    localparam int NUM_REGS  = 6;
    localparam int NUM_ROWS  = 3;
    localparam int IDX_W     = 3;
    localparam int IDX_LSB   = 3;
    localparam int ADDR_W    = IDX_W + IDX_LSB;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic [REG_W-1:0]         t_reg;

    // One matrix row as the lanes see it
    typedef struct packed {
        t_word c0;
        t_word c1;
        t_word c2;
        t_word offset;
    } t_row_cfg;

    // Load enables for the two lane stages
    typedef struct packed {
        logic s1;
        logic s2;
    } t_stage_en;

    typedef enum logic [IDX_W-1:0] {
        REG_ROW0_COLS01      = 3'd0,
        REG_ROW0_COL2_OFFSET = 3'd1,
        REG_ROW1_COLS01      = 3'd2,
        REG_ROW1_COL2_OFFSET = 3'd3,
        REG_ROW2_COLS01      = 3'd4,
        REG_ROW2_COL2_OFFSET = 3'd5
    } t_reg_idx;

    typedef enum logic {
        KIND_POINT     = 1'b0,
        KIND_DIRECTION = 1'b1
    } t_kind;

endpackage

// File: design/fixed_point_affine_vertex_transform_top.sv
// An accepted input transaction passes the product, sum and merge registers before o_valid.
// Throughput: one transaction per cycle while the output is not blocked; the three row lanes run in parallel.
// o_ready drops only when all three pipeline stages hold data and i_ready is low.
// Reset (i_rst_n low, synchronous) empties the pipeline and clears the matrix to zero.
// Depends on fpavt_pkg, fpavt_regs, fpavt_lane and fpavt_merge.
module fixed_point_affine_vertex_transform_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_kind,
    input  logic signed [31:0]             i_vec_x,
    input  logic signed [31:0]             i_vec_y,
    input  logic signed [31:0]             i_vec_z,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [31:0]             o_out_x,
    output logic signed [31:0]             o_out_y,
    output logic signed [31:0]             o_out_z,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fpavt_pkg::ADDR_W-1:0]   paddr,
    input  logic [63:0]                    pwdata,
    output logic [63:0]                    prdata,
    output logic                           pready
);

    fpavt_pkg::t_row_cfg  w_rows [fpavt_pkg::NUM_ROWS];
    fpavt_pkg::t_acc      w_sum  [fpavt_pkg::NUM_ROWS];
    fpavt_pkg::t_word     w_res  [fpavt_pkg::NUM_ROWS];
    fpavt_pkg::t_stage_en w_en;
    logic                 r_v1, r_v2;
    logic                 r_k1, r_k2;
    logic                 w_merge_ready;

    fpavt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_rows  (w_rows)
    );

    // Advance a stage when it is empty or the next one moves
    assign w_en.s2 = ~r_v2 | w_merge_ready;
    assign w_en.s1 = ~r_v1 | w_en.s2;
    assign o_ready = w_en.s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en.s1) begin
                r_v1 <= i_valid;
            end
            if (w_en.s2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Carry the kind bit alongside the lane data
    always_ff @(posedge i_clk) begin
        if (w_en.s1) begin
            r_k1 <= i_kind;
        end
        if (w_en.s2) begin
            r_k2 <= r_k1;
        end
    end

    for (genvar r = 0; r < fpavt_pkg::NUM_ROWS; r++) begin : g_lane
        fpavt_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_row   (w_rows[r]),
            .i_vec_x (i_vec_x),
            .i_vec_y (i_vec_y),
            .i_vec_z (i_vec_z),
            .o_sum   (w_sum[r])
        );
    end

    fpavt_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .i_kind  (r_k2),
        .i_sum   (w_sum),
        .i_rows  (w_rows),
        .o_ready (w_merge_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (w_res)
    );

    assign o_out_x = w_res[0];
    assign o_out_y = w_res[1];
    assign o_out_z = w_res[2];

`ifndef NO_ASSERTIONS
    // An accepted transaction must land in stage 1
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_v1)
        else $error("accepted transaction lost before stage 1");

    // Input stalls only when every stage is full and the output is blocked
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_v1 && r_v2 && o_valid && !i_ready))
        else $error("input stalled with a free pipeline stage");

    // A blocked stage 2 keeps its transaction
    a_s2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !w_merge_ready |=> r_v2 && $stable(r_k2))
        else $error("stage 2 dropped a transaction under stall");
`endif

endmodule

// File: design/fpavt_regs.sv
// Matrix register file behind the APB-style configuration port.
// Depends on fpavt_pkg for register indexes and the row layout.
module fpavt_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fpavt_pkg::ADDR_W-1:0]   paddr,
    input  fpavt_pkg::t_reg                pwdata,
    output fpavt_pkg::t_reg                prdata,
    output logic                           pready,
    output fpavt_pkg::t_row_cfg            o_rows [fpavt_pkg::NUM_ROWS]
);

    fpavt_pkg::t_reg     r_regs [fpavt_pkg::NUM_REGS];
    fpavt_pkg::t_reg_idx w_idx;
    logic                w_wr;

    assign pready = 1'b1;
    assign w_idx  = fpavt_pkg::t_reg_idx'(paddr[fpavt_pkg::ADDR_W-1:fpavt_pkg::IDX_LSB]);
    assign w_wr   = psel & penable & pwrite;

    // Write on the access cycle; drop writes beyond the last register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fpavt_pkg::NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
        end else if (w_wr) begin
            unique case (w_idx)
                fpavt_pkg::REG_ROW0_COLS01:      r_regs[fpavt_pkg::REG_ROW0_COLS01]      <= pwdata;
                fpavt_pkg::REG_ROW0_COL2_OFFSET: r_regs[fpavt_pkg::REG_ROW0_COL2_OFFSET] <= pwdata;
                fpavt_pkg::REG_ROW1_COLS01:      r_regs[fpavt_pkg::REG_ROW1_COLS01]      <= pwdata;
                fpavt_pkg::REG_ROW1_COL2_OFFSET: r_regs[fpavt_pkg::REG_ROW1_COL2_OFFSET] <= pwdata;
                fpavt_pkg::REG_ROW2_COLS01:      r_regs[fpavt_pkg::REG_ROW2_COLS01]      <= pwdata;
                fpavt_pkg::REG_ROW2_COL2_OFFSET: r_regs[fpavt_pkg::REG_ROW2_COL2_OFFSET] <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (w_idx)
            fpavt_pkg::REG_ROW0_COLS01:      prdata = r_regs[fpavt_pkg::REG_ROW0_COLS01];
            fpavt_pkg::REG_ROW0_COL2_OFFSET: prdata = r_regs[fpavt_pkg::REG_ROW0_COL2_OFFSET];
            fpavt_pkg::REG_ROW1_COLS01:      prdata = r_regs[fpavt_pkg::REG_ROW1_COLS01];
            fpavt_pkg::REG_ROW1_COL2_OFFSET: prdata = r_regs[fpavt_pkg::REG_ROW1_COL2_OFFSET];
            fpavt_pkg::REG_ROW2_COLS01:      prdata = r_regs[fpavt_pkg::REG_ROW2_COLS01];
            fpavt_pkg::REG_ROW2_COL2_OFFSET: prdata = r_regs[fpavt_pkg::REG_ROW2_COL2_OFFSET];
            default:                         prdata = '0;
        endcase
    end

    // Split each register pair into the row's coefficients and translation
    for (genvar r = 0; r < fpavt_pkg::NUM_ROWS; r++) begin : g_row
        assign o_rows[r].c0     = r_regs[2*r][fpavt_pkg::WORD_W-1:0];
        assign o_rows[r].c1     = r_regs[2*r][fpavt_pkg::REG_W-1:fpavt_pkg::WORD_W];
        assign o_rows[r].c2     = r_regs[2*r+1][fpavt_pkg::WORD_W-1:0];
        assign o_rows[r].offset = r_regs[2*r+1][fpavt_pkg::REG_W-1:fpavt_pkg::WORD_W];
    end

endmodule

// File: design/fpavt_lane.sv
// One row lane: three 32x32 signed products, then their 64-bit wrapped sum.
// Depends on fpavt_pkg; stage enables come from the top-level pipeline control.
module fpavt_lane (
    input  logic                  i_clk,
    input  fpavt_pkg::t_stage_en  i_en,
    input  fpavt_pkg::t_row_cfg   i_row,
    input  fpavt_pkg::t_word      i_vec_x,
    input  fpavt_pkg::t_word      i_vec_y,
    input  fpavt_pkg::t_word      i_vec_z,
    output fpavt_pkg::t_acc       o_sum
);

    fpavt_pkg::t_acc n_p0, n_p1, n_p2;
    fpavt_pkg::t_acc r_p0, r_p1, r_p2;
    fpavt_pkg::t_acc n_sum, r_sum;

    // Signed operands extend to the 64-bit product width
    assign n_p0 = i_row.c0 * i_vec_x;
    assign n_p1 = i_row.c1 * i_vec_y;
    assign n_p2 = i_row.c2 * i_vec_z;

    // Stage 1: hold the products
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_p0 <= n_p0;
            r_p1 <= n_p1;
            r_p2 <= n_p2;
        end
    end

    // Stage 2: sum with 64-bit wrap
    assign n_sum = r_p0 + r_p1 + r_p2;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

// File: design/fpavt_merge.sv
// Merge stage: scale each lane sum, add translation for points, hold the result transaction.
// Depends on fpavt_pkg; sits between the lanes and the output channel.
module fpavt_merge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_kind,
    input  fpavt_pkg::t_acc      i_sum [fpavt_pkg::NUM_ROWS],
    input  fpavt_pkg::t_row_cfg  i_rows [fpavt_pkg::NUM_ROWS],
    output logic                 o_ready,
    output logic                 o_valid,
    input  logic                 i_ready,
    output fpavt_pkg::t_word     o_res [fpavt_pkg::NUM_ROWS]
);

    logic             r_valid;
    fpavt_pkg::t_word n_res [fpavt_pkg::NUM_ROWS];
    fpavt_pkg::t_word r_res [fpavt_pkg::NUM_ROWS];
    logic             w_load;

    assign o_ready = ~r_valid | i_ready;
    assign w_load  = i_valid & o_ready;

    // Shift out the fraction, keep 32 bits, add translation for points
    for (genvar r = 0; r < fpavt_pkg::NUM_ROWS; r++) begin : g_row
        fpavt_pkg::t_acc  w_shift;
        fpavt_pkg::t_word w_trunc;
        fpavt_pkg::t_word w_add;

        assign w_shift  = i_sum[r] >>> fpavt_pkg::FRAC_BITS;
        assign w_trunc  = w_shift[fpavt_pkg::WORD_W-1:0];
        assign w_add    = (i_kind == fpavt_pkg::KIND_DIRECTION) ? '0 : i_rows[r].offset;
        assign n_res[r] = w_trunc + w_add;
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for fixed_point_affine_vertex_transform_top.
// Drives vertices and APB matrix writes and checks every result against a built-in predictor.
// Depends on fpavt_pkg and the RTL top level only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 110;

    // Indexes past the last matrix register; writes there must be ignored
    localparam logic [fpavt_pkg::IDX_W-1:0] REG_IDX_SPARE6 = 3'd6;
    localparam logic [fpavt_pkg::IDX_W-1:0] REG_IDX_SPARE7 = 3'd7;

    // Coefficient styles for a random matrix
    localparam int COEF_FULL    = 0;
    localparam int COEF_UNITY   = 1;
    localparam int COEF_EXTREME = 2;

    localparam fpavt_pkg::t_word WORD_MAX = 32'sh7fff_ffff;
    localparam fpavt_pkg::t_word WORD_MIN = fpavt_pkg::t_word'(32'h8000_0000);
    localparam fpavt_pkg::t_word ONE_FX   = fpavt_pkg::t_word'(1 << fpavt_pkg::FRAC_BITS);

    typedef struct packed {
        fpavt_pkg::t_kind kind;
        fpavt_pkg::t_word x;
        fpavt_pkg::t_word y;
        fpavt_pkg::t_word z;
    } t_vertex;

    typedef struct packed {
        fpavt_pkg::t_word x;
        fpavt_pkg::t_word y;
        fpavt_pkg::t_word z;
    } t_position;

    logic                          i_clk     = 1'b0;
    logic                          i_rst_n   = 1'b0;
    logic                          i_valid   = 1'b0;
    logic                          o_ready;
    logic                          i_kind    = 1'b0;
    logic signed [31:0]            i_vec_x   = '0;
    logic signed [31:0]            i_vec_y   = '0;
    logic signed [31:0]            i_vec_z   = '0;
    logic                          o_valid;
    logic                          i_ready   = 1'b0;
    logic signed [31:0]            o_out_x;
    logic signed [31:0]            o_out_y;
    logic signed [31:0]            o_out_z;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [fpavt_pkg::ADDR_W-1:0]  paddr     = '0;
    logic [63:0]                   pwdata    = '0;
    logic [63:0]                   prdata;
    logic                          pready;

    fpavt_pkg::t_reg mat_shadow [fpavt_pkg::NUM_REGS];
    fpavt_pkg::t_reg matrix_next [fpavt_pkg::NUM_REGS];
    t_vertex         pending_vertices [$];
    t_position       expected_positions [$];
    int              n_errors     = 0;
    int              quiet_cycles = 0;
    bit              tx_steady    = 1'b0;
    bit              rx_steady    = 1'b0;

    fixed_point_affine_vertex_transform_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_kind  (i_kind),
        .i_vec_x (i_vec_x),
        .i_vec_y (i_vec_y),
        .i_vec_z (i_vec_z),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out_x (o_out_x),
        .o_out_y (o_out_y),
        .o_out_z (o_out_z),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // One matrix row: exact products, 64-bit wrapping sum, arithmetic shift, cut, translate points
    function automatic fpavt_pkg::t_word transform_row(input fpavt_pkg::t_reg cols01,
                                                       input fpavt_pkg::t_reg col2_ofs,
                                                       input t_vertex v);
        fpavt_pkg::t_word c0, c1, c2, ofs, r;
        fpavt_pkg::t_acc  acc;
        c0  = cols01[31:0];
        c1  = cols01[63:32];
        c2  = col2_ofs[31:0];
        ofs = col2_ofs[63:32];
        acc = fpavt_pkg::t_acc'(c0) * fpavt_pkg::t_acc'(v.x)
            + fpavt_pkg::t_acc'(c1) * fpavt_pkg::t_acc'(v.y)
            + fpavt_pkg::t_acc'(c2) * fpavt_pkg::t_acc'(v.z);
        r   = fpavt_pkg::t_word'(acc >>> fpavt_pkg::FRAC_BITS);
        if (v.kind == fpavt_pkg::KIND_POINT) begin
            r = r + ofs;
        end
        return r;
    endfunction

    function automatic t_position transform_vertex(input t_vertex v);
        t_position p;
        p.x = transform_row(mat_shadow[fpavt_pkg::REG_ROW0_COLS01],
                            mat_shadow[fpavt_pkg::REG_ROW0_COL2_OFFSET], v);
        p.y = transform_row(mat_shadow[fpavt_pkg::REG_ROW1_COLS01],
                            mat_shadow[fpavt_pkg::REG_ROW1_COL2_OFFSET], v);
        p.z = transform_row(mat_shadow[fpavt_pkg::REG_ROW2_COLS01],
                            mat_shadow[fpavt_pkg::REG_ROW2_COL2_OFFSET], v);
        return p;
    endfunction

    function automatic fpavt_pkg::t_word pick_extreme();
        case ($urandom_range(0, 5))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return -1;
            4:       return ONE_FX;
            default: return 1;
        endcase
    endfunction

    // Mostly full-range words, with extremes and small magnitudes mixed in
    function automatic fpavt_pkg::t_word pick_word();
        case ($urandom_range(0, 7))
            0:       return pick_extreme();
            1, 2:    return fpavt_pkg::t_word'(int'($urandom_range(0, 131071)) - 65536);
            default: return fpavt_pkg::t_word'($urandom());
        endcase
    endfunction

    function automatic fpavt_pkg::t_word pick_coef(input int style);
        case (style)
            COEF_FULL:  return fpavt_pkg::t_word'($urandom());
            COEF_UNITY: return fpavt_pkg::t_word'(int'($urandom_range(0, 16384)) - 8192);
            default:    return pick_extreme();
        endcase
    endfunction

    task automatic push_vertex(input fpavt_pkg::t_kind kind, input fpavt_pkg::t_word x,
                               input fpavt_pkg::t_word y, input fpavt_pkg::t_word z);
        t_vertex v;
        v.kind = kind;
        v.x    = x;
        v.y    = y;
        v.z    = z;
        pending_vertices.push_back(v);
    endtask

    // One APB transaction: setup cycle, then access until pready
    task automatic apb_access(input bit wr, input logic [fpavt_pkg::IDX_W-1:0] idx,
                              input fpavt_pkg::t_reg wdata, output fpavt_pkg::t_reg rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, {fpavt_pkg::IDX_LSB{1'b0}}};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        rdata = prdata;
        if (wr && idx < fpavt_pkg::NUM_REGS) begin
            mat_shadow[idx] = wdata;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write all six registers from matrix_next, then read each one back
    task automatic program_matrix();
        fpavt_pkg::t_reg rd;
        for (int i = 0; i < fpavt_pkg::NUM_REGS; i++) begin
            apb_access(1'b1, fpavt_pkg::IDX_W'(i), matrix_next[i], rd);
        end
        for (int i = 0; i < fpavt_pkg::NUM_REGS; i++) begin
            apb_access(1'b0, fpavt_pkg::IDX_W'(i), '0, rd);
            if (rd !== mat_shadow[i]) begin
                $error("register %0d readback: expected %h, actual %h", i, mat_shadow[i], rd);
                n_errors++;
            end
        end
    endtask

    task automatic random_matrix(input int style);
        for (int i = 0; i < fpavt_pkg::NUM_REGS; i += 2) begin
            matrix_next[i]   = {pick_coef(style), pick_coef(style)};
            matrix_next[i+1] = {pick_word(), pick_coef(style)};
        end
    endtask

    // Hold until every queued vertex is taken and every result has come back
    task automatic wait_drained();
        while (pending_vertices.size() != 0 || i_valid || expected_positions.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Vertex driver: hold the transaction until taken, then idle for a drawn gap
    int      tx_gap = 0;
    t_vertex tx_next;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap = 0;
        end else if (!i_valid || o_ready) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_valid <= 1'b0;
            end else if (pending_vertices.size() != 0) begin
                tx_next = pending_vertices.pop_front();
                i_kind  <= tx_next.kind;
                i_vec_x <= tx_next.x;
                i_vec_y <= tx_next.y;
                i_vec_z <= tx_next.z;
                i_valid <= 1'b1;
                tx_gap = tx_steady ? 0 : $urandom_range(0, 10);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result receiver: drawn stall after each result, plus two long hold-offs
    int rx_wait  = 0;
    int rx_hold  = 0;
    int rx_taken = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_wait = 0;
            rx_hold = 0;
            rx_taken = 0;
        end else begin
            if (o_valid && i_ready) begin
                rx_taken++;
                rx_wait = rx_steady ? 0 : $urandom_range(0, 10);
                if (rx_taken == 40 || rx_taken == 700) begin
                    rx_hold = HOLD_CYCLES;
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Monitor: predict on input transactions, compare on output transactions
    t_vertex   seen_vertex;
    t_position want;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                seen_vertex.kind = fpavt_pkg::t_kind'(i_kind);
                seen_vertex.x    = i_vec_x;
                seen_vertex.y    = i_vec_y;
                seen_vertex.z    = i_vec_z;
                expected_positions.push_back(transform_vertex(seen_vertex));
            end
            if (o_valid && i_ready) begin
                if (expected_positions.size() == 0) begin
                    $error("unexpected result: out_x %0d out_y %0d out_z %0d",
                           o_out_x, o_out_y, o_out_z);
                    n_errors++;
                end else begin
                    want = expected_positions.pop_front();
                    if (o_out_x !== want.x) begin
                        $error("out_x: expected %0d, actual %0d", want.x, o_out_x);
                        n_errors++;
                    end
                    if (o_out_y !== want.y) begin
                        $error("out_y: expected %0d, actual %0d", want.y, o_out_y);
                        n_errors++;
                    end
                    if (o_out_z !== want.z) begin
                        $error("out_z: expected %0d, actual %0d", want.z, o_out_z);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("FAIL fixed_point_affine_vertex_transform_top");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sequencer: reset, directed phases, then random phases, each with its own matrix
    initial begin
        fpavt_pkg::t_reg rd;
        for (int i = 0; i < fpavt_pkg::NUM_REGS; i++) begin
            mat_shadow[i] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Matrix left at reset: everything transforms to zero
        push_vertex(fpavt_pkg::KIND_POINT, WORD_MAX, WORD_MIN, -1);
        push_vertex(fpavt_pkg::KIND_DIRECTION, WORD_MIN, WORD_MAX, 1);
        wait_drained();

        // Unit matrix, row 0 and row 1 translations at the extremes to wrap the final add
        matrix_next[fpavt_pkg::REG_ROW0_COLS01]      = {32'd0, ONE_FX};
        matrix_next[fpavt_pkg::REG_ROW0_COL2_OFFSET] = {WORD_MAX, 32'd0};
        matrix_next[fpavt_pkg::REG_ROW1_COLS01]      = {ONE_FX, 32'd0};
        matrix_next[fpavt_pkg::REG_ROW1_COL2_OFFSET] = {WORD_MIN, 32'd0};
        matrix_next[fpavt_pkg::REG_ROW2_COLS01]      = {32'd0, 32'd0};
        matrix_next[fpavt_pkg::REG_ROW2_COL2_OFFSET] = {32'd1, ONE_FX};
        program_matrix();
        push_vertex(fpavt_pkg::KIND_POINT, WORD_MAX, WORD_MAX, WORD_MAX);
        push_vertex(fpavt_pkg::KIND_DIRECTION, WORD_MIN, WORD_MIN, WORD_MIN);
        push_vertex(fpavt_pkg::KIND_POINT, 0, 0, 0);
        push_vertex(fpavt_pkg::KIND_DIRECTION, 0, 0, 0);
        push_vertex(fpavt_pkg::KIND_POINT, 1, -1, 4095);
        push_vertex(fpavt_pkg::KIND_POINT, ONE_FX, -ONE_FX, 12345);
        push_vertex(fpavt_pkg::KIND_DIRECTION, -1, 1, 32'sh1234_5678);
        push_vertex(fpavt_pkg::KIND_POINT, WORD_MIN, WORD_MAX, 0);
        wait_drained();

        // Extreme coefficients overflow the 64-bit sum; spare indexes must not land
        matrix_next[fpavt_pkg::REG_ROW0_COLS01]      = {WORD_MIN, WORD_MIN};
        matrix_next[fpavt_pkg::REG_ROW0_COL2_OFFSET] = {WORD_MAX, WORD_MIN};
        matrix_next[fpavt_pkg::REG_ROW1_COLS01]      = {WORD_MAX, WORD_MAX};
        matrix_next[fpavt_pkg::REG_ROW1_COL2_OFFSET] = {WORD_MIN, WORD_MAX};
        matrix_next[fpavt_pkg::REG_ROW2_COLS01]      = {WORD_MIN, -32'sd1};
        matrix_next[fpavt_pkg::REG_ROW2_COL2_OFFSET] = {-32'sd1, WORD_MAX};
        program_matrix();
        apb_access(1'b1, REG_IDX_SPARE6, '1, rd);
        apb_access(1'b1, REG_IDX_SPARE7, '1, rd);
        push_vertex(fpavt_pkg::KIND_POINT, WORD_MIN, WORD_MIN, WORD_MIN);
        push_vertex(fpavt_pkg::KIND_DIRECTION, WORD_MIN, WORD_MIN, WORD_MIN);
        push_vertex(fpavt_pkg::KIND_POINT, WORD_MAX, WORD_MAX, WORD_MAX);
        push_vertex(fpavt_pkg::KIND_DIRECTION, WORD_MAX, WORD_MIN, WORD_MAX);
        push_vertex(fpavt_pkg::KIND_POINT, WORD_MIN, 0, WORD_MAX);
        wait_drained();

        // All ones: every coefficient and translation is minus one
        for (int i = 0; i < fpavt_pkg::NUM_REGS; i++) begin
            matrix_next[i] = '1;
        end
        program_matrix();
        push_vertex(fpavt_pkg::KIND_POINT, ONE_FX, ONE_FX, ONE_FX);
        push_vertex(fpavt_pkg::KIND_DIRECTION, -1, -1, -1);
        push_vertex(fpavt_pkg::KIND_POINT, WORD_MAX, 0, WORD_MIN);
        wait_drained();

        // Random phases, each with a new matrix and its own idling pattern
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_matrix(ph % 3);
            program_matrix();
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                push_vertex(fpavt_pkg::t_kind'($urandom_range(0, 1)), pick_word(),
                            pick_word(), pick_word());
            end
            wait_drained();
        end

        if (n_errors == 0) begin
            $display("PASS fixed_point_affine_vertex_transform_top");
        end else begin
            $display("FAIL fixed_point_affine_vertex_transform_top");
        end
        $finish;
    end

endmodule
